[rtl/core/alf_pkg.sv]
package alf_pkg;

    // Operation codes
    localparam logic [3:0] OP_EQ  = 4'd0;
    localparam logic [3:0] OP_NE  = 4'd1;
    localparam logic [3:0] OP_LT  = 4'd2;
    localparam logic [3:0] OP_LE  = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_GE  = 4'd5;
    localparam logic [3:0] OP_AND = 4'd6;
    localparam logic [3:0] OP_OR  = 4'd7;
    localparam logic [3:0] OP_NOT = 4'd8;
    localparam logic [3:0] OP_ADD = 4'd9;
    localparam logic [3:0] OP_SUB = 4'd10;
    localparam logic [3:0] OP_MUL = 4'd11;
    localparam logic [3:0] OP_DIV = 4'd12;

    // Operand type codes
    localparam logic [2:0] TY_BOOL = 3'd0;
    localparam logic [2:0] TY_I8   = 3'd1;
    localparam logic [2:0] TY_I16  = 3'd2;
    localparam logic [2:0] TY_I32  = 3'd3;
    localparam logic [2:0] TY_I64  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_NOFOLD   = 2'd3;

    localparam int DIV_STAGES = 64;

    // Partial result that travels down the pipeline with each request
    typedef struct packed {
        logic        is_mul;
        logic        is_div;
        logic        neg;
        logic [2:0]  vtype;
        logic [63:0] value;
        logic [2:0]  rtype;
        logic [1:0]  status;
    } alf_side_t;

    function automatic logic [63:0] sext_type(input logic [63:0] v, input logic [2:0] ty);
        logic [63:0] r;
        case (ty)
            TY_I8:   r = {{56{v[7]}}, v[7:0]};
            TY_I16:  r = {{48{v[15]}}, v[15:0]};
            TY_I32:  r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] type_min(input logic [2:0] ty);
        logic [63:0] r;
        case (ty)
            TY_I8:   r = {{57{1'b1}}, 7'b0};
            TY_I16:  r = {{49{1'b1}}, 15'b0};
            TY_I32:  r = {{33{1'b1}}, 31'b0};
            default: r = {1'b1, 63'b0};
        endcase
        return r;
    endfunction

    // True when a signed 128-bit value fits the integer type
    function automatic logic fits_type(input logic [127:0] x, input logic [2:0] ty);
        logic r;
        case (ty)
            TY_I8:   r = (x == {{120{x[7]}}, x[7:0]});
            TY_I16:  r = (x == {{112{x[15]}}, x[15:0]});
            TY_I32:  r = (x == {{96{x[31]}}, x[31:0]});
            default: r = (x == {{64{x[63]}}, x[63:0]});
        endcase
        return r;
    endfunction

endpackage

[rtl/core/alf_front.sv]
module alf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [3:0]          op,
    input  logic [2:0]          opnd_type,
    input  logic [63:0]         left_value,
    input  logic [63:0]         right_value,
    output logic                front_valid,
    output alf_pkg::alf_side_t  front_side,
    output logic [63:0]         mag_a,
    output logic [63:0]         mag_b
);
    import alf_pkg::*;

    logic        v0_reg;
    logic [3:0]  op0_reg;
    logic [2:0]  ty0_reg;
    logic [63:0] a0_reg;
    logic [63:0] b0_reg;

    logic        v1_reg;
    alf_side_t   side1_reg;
    alf_side_t   side1_next;
    logic [63:0] ma1_reg;
    logic [63:0] mb1_reg;

    logic [64:0]  sum;
    logic [64:0]  dif;
    logic [63:0]  tmin;
    logic         ba;
    logic         bb;

    // Stage 0: capture operands sign-extended from the type width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg <= op;
            ty0_reg <= opnd_type;
            a0_reg  <= sext_type(left_value, opnd_type);
            b0_reg  <= sext_type(right_value, opnd_type);
        end
    end

    assign sum  = {a0_reg[63], a0_reg} + {b0_reg[63], b0_reg};
    assign dif  = {a0_reg[63], a0_reg} - {b0_reg[63], b0_reg};
    assign tmin = type_min(ty0_reg);
    assign ba   = (a0_reg != 64'd0);
    assign bb   = (b0_reg != 64'd0);

    // Stage 1: resolve compare, logic, add and subtract; flag multiply and divide
    always_comb
    begin
        side1_next        = '0;
        side1_next.neg    = a0_reg[63] ^ b0_reg[63];
        side1_next.vtype  = ty0_reg;
        side1_next.rtype  = ty0_reg;
        side1_next.status = ST_OK;
        case (ty0_reg)
            TY_BOOL:
            begin
                case (op0_reg)
                    OP_EQ:   side1_next.value[0] = (ba == bb);
                    OP_NE:   side1_next.value[0] = (ba != bb);
                    OP_LT:   side1_next.value[0] = !ba && bb;
                    OP_LE:   side1_next.value[0] = !ba || bb;
                    OP_GT:   side1_next.value[0] = ba && !bb;
                    OP_GE:   side1_next.value[0] = ba || !bb;
                    OP_AND:  side1_next.value[0] = ba && bb;
                    OP_OR:   side1_next.value[0] = ba || bb;
                    OP_NOT:  side1_next.value[0] = !ba;
                    default: side1_next.status   = ST_NOFOLD;
                endcase
            end
            TY_I8, TY_I16, TY_I32, TY_I64:
            begin
                case (op0_reg)
                    OP_EQ:
                    begin
                        side1_next.rtype    = TY_BOOL;
                        side1_next.value[0] = (a0_reg == b0_reg);
                    end
                    OP_NE:
                    begin
                        side1_next.rtype    = TY_BOOL;
                        side1_next.value[0] = (a0_reg != b0_reg);
                    end
                    OP_LT:
                    begin
                        side1_next.rtype    = TY_BOOL;
                        side1_next.value[0] = ($signed(a0_reg) < $signed(b0_reg));
                    end
                    OP_LE:
                    begin
                        side1_next.rtype    = TY_BOOL;
                        side1_next.value[0] = ($signed(a0_reg) <= $signed(b0_reg));
                    end
                    OP_GT:
                    begin
                        side1_next.rtype    = TY_BOOL;
                        side1_next.value[0] = ($signed(a0_reg) > $signed(b0_reg));
                    end
                    OP_GE:
                    begin
                        side1_next.rtype    = TY_BOOL;
                        side1_next.value[0] = ($signed(a0_reg) >= $signed(b0_reg));
                    end
                    OP_ADD:
                    begin
                        if (fits_type({{63{sum[64]}}, sum}, ty0_reg))
                            side1_next.value = sum[63:0];
                        else
                            side1_next.status = ST_OVERFLOW;
                    end
                    OP_SUB:
                    begin
                        if (fits_type({{63{dif[64]}}, dif}, ty0_reg))
                            side1_next.value = dif[63:0];
                        else
                            side1_next.status = ST_OVERFLOW;
                    end
                    OP_MUL:
                    begin
                        // Negative right operand with a type minimum always overflows
                        if (b0_reg[63] && (a0_reg == tmin || b0_reg == tmin))
                            side1_next.status = ST_OVERFLOW;
                        else
                            side1_next.is_mul = 1'b1;
                    end
                    OP_DIV:
                    begin
                        if (b0_reg == 64'd0)
                            side1_next.status = ST_DIVZERO;
                        else if (a0_reg == tmin && b0_reg == {64{1'b1}})
                            side1_next.status = ST_OVERFLOW;
                        else
                            side1_next.is_div = 1'b1;
                    end
                    default: side1_next.status = ST_NOFOLD;
                endcase
            end
            default:
            begin
                side1_next.rtype  = TY_BOOL;
                side1_next.status = ST_NOFOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side1_next;
            ma1_reg   <= a0_reg[63] ? (64'd0 - a0_reg) : a0_reg;
            mb1_reg   <= b0_reg[63] ? (64'd0 - b0_reg) : b0_reg;
        end
    end

    assign front_valid = v1_reg;
    assign front_side  = side1_reg;
    assign mag_a       = ma1_reg;
    assign mag_b       = mb1_reg;

endmodule

[rtl/core/alf_mul.sv]
module alf_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  alf_pkg::alf_side_t  in_side,
    input  logic [63:0]         in_ma,
    input  logic [63:0]         in_mb,
    output logic                out_vld,
    output alf_pkg::alf_side_t  out_side,
    output logic [63:0]         out_ma,
    output logic [63:0]         out_mb
);
    import alf_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    alf_side_t   s1_reg, s2_reg, s3_reg;
    alf_side_t   s3_next;
    logic [63:0] ma1_reg, ma2_reg, ma3_reg;
    logic [63:0] mb1_reg, mb2_reg, mb3_reg;
    logic [63:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0] sum_reg;
    logic [127:0] prod;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign prod = s2_reg.neg ? (128'd0 - sum_reg) : sum_reg;

    // Apply sign, then check the product against the type range
    always_comb
    begin
        s3_next = s2_reg;
        if (s2_reg.is_mul)
        begin
            if (fits_type(prod, s2_reg.vtype))
                s3_next.value = prod[63:0];
            else
                s3_next.status = ST_OVERFLOW;
        end
    end

    // Partial products, sum, sign and range check
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_ll_reg <= in_ma[31:0]  * in_mb[31:0];
            pp_lh_reg <= in_ma[31:0]  * in_mb[63:32];
            pp_hl_reg <= in_ma[63:32] * in_mb[31:0];
            pp_hh_reg <= in_ma[63:32] * in_mb[63:32];
            s1_reg    <= in_side;
            ma1_reg   <= in_ma;
            mb1_reg   <= in_mb;

            sum_reg <= {64'd0, pp_ll_reg} + {32'd0, pp_lh_reg, 32'd0}
                     + {32'd0, pp_hl_reg, 32'd0} + {pp_hh_reg, 64'd0};
            s2_reg  <= s1_reg;
            ma2_reg <= ma1_reg;
            mb2_reg <= mb1_reg;

            s3_reg  <= s3_next;
            ma3_reg <= ma2_reg;
            mb3_reg <= mb2_reg;
        end
    end

    assign out_vld  = v3_reg;
    assign out_side = s3_reg;
    assign out_ma   = ma3_reg;
    assign out_mb   = mb3_reg;

endmodule

[rtl/core/alf_div.sv]
module alf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  alf_pkg::alf_side_t  in_side,
    input  logic [63:0]         in_ma,
    input  logic [63:0]         in_mb,
    output logic                out_vld,
    output alf_pkg::alf_side_t  out_side,
    output logic [63:0]         out_quot
);
    import alf_pkg::*;

    logic        vld_s  [0:DIV_STAGES];
    alf_side_t   side_s [0:DIV_STAGES];
    logic [63:0] rem_s  [0:DIV_STAGES];
    logic [63:0] nq_s   [0:DIV_STAGES];
    logic [63:0] d_s    [0:DIV_STAGES];

    assign vld_s[0]  = in_vld;
    assign side_s[0] = in_side;
    assign rem_s[0]  = 64'd0;
    assign nq_s[0]   = in_ma;
    assign d_s[0]    = in_mb;

    // One restoring step per stage: dividend bits shift out, quotient bits shift in
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [64:0] trial;
        logic [64:0] diff;
        logic        take;

        assign trial = {rem_s[k], nq_s[k][63]};
        assign diff  = trial - {1'b0, d_s[k]};
        assign take  = !diff[64];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_s[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_s[k+1] <= vld_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_s[k+1] <= side_s[k];
                rem_s[k+1]  <= take ? diff[63:0] : trial[63:0];
                nq_s[k+1]   <= {nq_s[k][62:0], take};
                d_s[k+1]    <= d_s[k];
            end
        end
    end

    assign out_vld  = vld_s[DIV_STAGES];
    assign out_side = side_s[DIV_STAGES];
    assign out_quot = nq_s[DIV_STAGES];

endmodule

[rtl/core/checked_typed_alu_fold_top.sv]
// Overflow-checked integer fold unit. Each request carries an operation, an operand type and
// two operands, which the unit sign-extends from the type width, and yields one result: value,
// result type and status. The unit takes one request per cycle while in_stall is low. Every
// request passes through 70 register stages; that depth is set by the 64-stage restoring
// divider, which every request passes through so results leave in order. Two front stages,
// three multiplier stages and one output register make up the rest. out_stall freezes the
// whole pipeline while a result is held, and in_stall follows it.
module checked_typed_alu_fold_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  op,
    input  logic [2:0]  opnd_type,
    input  logic [63:0] left_value,
    input  logic [63:0] right_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_value,
    output logic [2:0]  res_type,
    output logic [1:0]  status
);
    import alf_pkg::*;

    logic        adv;
    logic        f_vld, m_vld, d_vld;
    alf_side_t   f_side, m_side, d_side;
    logic [63:0] f_ma, f_mb, m_ma, m_mb;
    logic [63:0] d_quot;
    logic [63:0] fin_value;

    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [2:0]  rtype_reg;
    logic [1:0]  status_reg;

    // Advance whenever the output register is free or being drained
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    alf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .op           (op),
        .opnd_type    (opnd_type),
        .left_value   (left_value),
        .right_value  (right_value),
        .front_valid  (f_vld),
        .front_side   (f_side),
        .mag_a        (f_ma),
        .mag_b        (f_mb)
    );

    alf_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (f_vld),
        .in_side  (f_side),
        .in_ma    (f_ma),
        .in_mb    (f_mb),
        .out_vld  (m_vld),
        .out_side (m_side),
        .out_ma   (m_ma),
        .out_mb   (m_mb)
    );

    alf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (m_vld),
        .in_side  (m_side),
        .in_ma    (m_ma),
        .in_mb    (m_mb),
        .out_vld  (d_vld),
        .out_side (d_side),
        .out_quot (d_quot)
    );

    // Sign the quotient for divides; other operations are already resolved
    always_comb
    begin
        fin_value = d_side.value;
        if (d_side.is_div)
            fin_value = d_side.neg ? (64'd0 - d_quot) : d_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg  <= fin_value;
            rtype_reg  <= d_side.rtype;
            status_reg <= d_side.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign res_type     = rtype_reg;
    assign status       = status_reg;

endmodule

[rtl/core/alf_checker.sv]
module alf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result_value,
    input logic [2:0]  res_type,
    input logic [1:0]  status
);
    import alf_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
        else $error("stalled result changed");

    // Drop the value on any error status
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_value == 64'd0)
        else $error("nonzero value with error status");

    // Keep boolean results at zero or one
    a_bool: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && res_type == TY_BOOL |-> result_value[63:1] == 63'd0)
        else $error("boolean result out of range");

    // Divide by zero only arises on an integer type
    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIVZERO |->
            res_type == TY_I8 || res_type == TY_I16 ||
            res_type == TY_I32 || res_type == TY_I64)
        else $error("divide by zero on non-integer type");

endmodule

bind checked_typed_alu_fold_top alf_checker u_alf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .res_type     (res_type),
    .status       (status)
);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import alf_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  rtype;
        logic [1:0]  status;
    } fold_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  op;
    logic [2:0]  opnd_type;
    logic [63:0] left_value;
    logic [63:0] right_value;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_value;
    logic [2:0]  res_type;
    logic [1:0]  status;

    fold_t pending_folds[$];
    int    mismatches;
    int    requests_sent;
    int    results_seen;
    int    overflow_seen;
    int    divzero_seen;
    int    nofold_seen;
    bit    steady;

    checked_typed_alu_fold_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .opnd_type    (opnd_type),
        .left_value   (left_value),
        .right_value  (right_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .res_type     (res_type),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sign-extend the low bits of a field at the type width
    function automatic longint sext_width(input logic [63:0] v, input int w);
        return longint'(v << (64 - w)) >>> (64 - w);
    endfunction

    // Fold one request at the type width, with the overflow checks
    function automatic fold_t fold_expect(input logic [3:0] o, input logic [2:0] ty,
                                          input logic [63:0] l, input logic [63:0] r);
        fold_t  e;
        longint a, b, tmax, tmin, ca, cb;
        int     w;
        logic   la, lb;
        e.value  = '0;
        e.rtype  = ty;
        e.status = ST_OK;
        if (ty > TY_I64)
        begin
            e.rtype  = TY_BOOL;
            e.status = ST_NOFOLD;
        end
        else if (ty == TY_BOOL)
        begin
            la = |l;
            lb = |r;
            case (o)
                OP_EQ:   e.value[0] = (la == lb);
                OP_NE:   e.value[0] = (la != lb);
                OP_LT:   e.value[0] = !la && lb;
                OP_LE:   e.value[0] = !la || lb;
                OP_GT:   e.value[0] = la && !lb;
                OP_GE:   e.value[0] = la || !lb;
                OP_AND:  e.value[0] = la && lb;
                OP_OR:   e.value[0] = la || lb;
                OP_NOT:  e.value[0] = !la;
                default: e.status = ST_NOFOLD;
            endcase
        end
        else
        begin
            w    = 4 << ty;
            a    = sext_width(l, w);
            b    = sext_width(r, w);
            tmax = (w == 64) ? 64'sh7fff_ffff_ffff_ffff : (64'sd1 <<< (w - 1)) - 1;
            tmin = -tmax - 1;
            case (o)
                OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE:
                begin
                    e.rtype = TY_BOOL;
                    case (o)
                        OP_EQ:   e.value[0] = (a == b);
                        OP_NE:   e.value[0] = (a != b);
                        OP_LT:   e.value[0] = (a < b);
                        OP_LE:   e.value[0] = (a <= b);
                        OP_GT:   e.value[0] = (a > b);
                        default: e.value[0] = (a >= b);
                    endcase
                end
                OP_ADD:
                    if ((b < 0 && a < tmin - b) || (b >= 0 && a > tmax - b))
                        e.status = ST_OVERFLOW;
                    else
                        e.value = sext_width(a + b, w);
                OP_SUB:
                    if ((b < 0 && a > tmax + b) || (b >= 0 && a < tmin + b))
                        e.status = ST_OVERFLOW;
                    else
                        e.value = sext_width(a - b, w);
                OP_MUL:
                    if (b != 0)
                    begin
                        ca = a;
                        cb = b;
                        // negative right operand with a type minimum always overflows
                        if (b < 0)
                        begin
                            if (a == tmin || b == tmin)
                                e.status = ST_OVERFLOW;
                            else
                            begin
                                ca = -a;
                                cb = -b;
                            end
                        end
                        if (e.status == ST_OK && (ca > tmax / cb || ca < tmin / cb))
                            e.status = ST_OVERFLOW;
                        if (e.status == ST_OK)
                            e.value = sext_width(a * b, w);
                    end
                OP_DIV:
                    if (b == 0)
                        e.status = ST_DIVZERO;
                    else if (a == tmin && b == -1)
                        e.status = ST_OVERFLOW;
                    else
                        e.value = sext_width(a / b, w);
                default:
                    e.status = ST_NOFOLD;
            endcase
        end
        if (e.status != ST_OK)
            e.value = '0;
        return e;
    endfunction

    // Roll whether a side idles this cycle
    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < 38);
    endfunction

    // Drive one request and hold it until accepted
    task automatic send_request(input logic [3:0] o, input logic [2:0] ty,
                                input logic [63:0] l, input logic [63:0] r);
        bit taken;
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        opnd_type    <= ty;
        left_value   <= l;
        right_value  <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        pending_folds = {pending_folds, fold_expect(o, ty, l, r)};
        requests_sent++;
    endtask

    // Pick an operand biased to the edges of the type
    function automatic logic [63:0] pick_operand(input logic [2:0] ty);
        int w;
        w = (ty >= TY_I8 && ty <= TY_I64) ? (4 << ty) : 64;
        case ($urandom_range(9))
            0:       return sext_width(64'h1 << (w - 1), w);
            1:       return sext_width(~(64'h1 << (w - 1)), w);
            2:       return 64'd0;
            3:       return 64'd1;
            4:       return '1;
            5:       return sext_width(64'($signed($urandom_range(15)) - 8), w);
            6:       return {$urandom, $urandom};
            default: return sext_width({$urandom, $urandom}, w);
        endcase
    endfunction

    // Drive output stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_roll();
    end

    // Check each result against the oldest pending fold
    always @(negedge clk)
    begin
        fold_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_folds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h type=%0d status=%0d",
                             result_value, res_type, status);
            end
            else
            begin
                e = pending_folds.pop_front();
                if (e.status == ST_OVERFLOW) overflow_seen++;
                if (e.status == ST_DIVZERO)  divzero_seen++;
                if (e.status == ST_NOFOLD)   nofold_seen++;
                if (result_value !== e.value || res_type !== e.rtype
                    || status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                 e.value, e.rtype, e.status,
                                 result_value, res_type, status);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(OP_EQ, TY_I64, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        send_request(OP_NE, TY_I64, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        send_request(OP_LT, TY_I64, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        send_request(OP_LE, TY_I8, 64'h7f, 64'h7f);
        send_request(OP_GT, TY_I16, 64'hffff_ffff_ffff_8000, 64'h7fff);
        send_request(OP_GE, TY_I32, '1, 64'd0);
        send_request(OP_AND, TY_BOOL, 64'h8000_0000_0000_0000, 64'd1);
        send_request(OP_OR, TY_BOOL, 64'd0, 64'd0);
        send_request(OP_NOT, TY_BOOL, 64'd0, '1);
        send_request(OP_ADD, TY_I8, 64'h7f, 64'd1);
        send_request(OP_SUB, TY_I16, 64'hffff_ffff_ffff_8000, 64'd1);
        send_request(OP_MUL, TY_I32, 64'hffff_ffff_8000_0000, '1);
        // zero times the minimum still reports overflow
        send_request(OP_MUL, TY_I8, 64'd0, 64'hffff_ffff_ffff_ff80);
        send_request(OP_MUL, TY_I64, 64'h1234_5678_9abc_def0, 64'd0);
        send_request(OP_DIV, TY_I32, 64'd5, 64'd0);
        send_request(OP_DIV, TY_I8, 64'hffff_ffff_ffff_ff80, '1);
        send_request(OP_DIV, TY_I64, -64'sd7, 64'd2);
        send_request(OP_ADD, TY_BOOL, 64'd1, 64'd1);
        send_request(OP_AND, TY_I32, 64'd1, 64'd1);
        send_request(4'd13, TY_I16, 64'd3, 64'd4);
        send_request(4'd15, TY_I64, 64'd3, 64'd4);
        send_request(OP_ADD, 3'd5, 64'd1, 64'd2);
        send_request(OP_EQ, 3'd7, 64'd1, 64'd1);
        // upper bits above the type width are ignored
        send_request(OP_ADD, TY_I8, 64'hffff_ffff_ffff_ff01, 64'h5555_0000_0000_0002);
    endtask

    task automatic test_random(input int count);
        logic [3:0] o;
        logic [2:0] ty;
        repeat (count)
        begin
            if ($urandom_range(9) < 8)
            begin
                o  = 4'($urandom_range(12));
                ty = (o >= OP_AND && o <= OP_NOT && $urandom_range(1)) ? TY_BOOL
                     : 3'($urandom_range(1, 4));
            end
            else
            begin
                o  = 4'($urandom_range(15));
                ty = 3'($urandom_range(7));
            end
            send_request(o, ty, pick_operand(ty), pick_operand(ty));
        end
    endtask

    // Hold off the sender until the pipeline is empty
    task automatic test_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_folds.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_no_idle(input int count);
        steady = 1'b1;
        test_random(count);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        steady        = 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_EQ;
        opnd_type    <= TY_BOOL;
        left_value   <= '0;
        right_value  <= '0;
        mismatches    = 0;
        requests_sent = 0;
        results_seen  = 0;
        overflow_seen = 0;
        divzero_seen  = 0;
        nofold_seen   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain();
        test_random(700);
        test_drain();
        test_no_idle(400);
        test_random(800);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_folds.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Folded %0d requests, %0d results checked, %0d mismatches.",
                 requests_sent, results_seen, mismatches);
        $display("Status mix: %0d overflow, %0d divide by zero, %0d not foldable.",
                 overflow_seen, divzero_seen, nofold_seen);
        if (mismatches == 0 && pending_folds.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("FAIL");
        $finish;
    end

endmodule
